// ===== hdl/lru_pkg.sv =====
// shared constants and payload types for the lru page frame replacement block
package lru_pkg;

    localparam int NUM_FRAMES = 16;
    localparam int ID_BITS    = 16;
    localparam int SIZE_BITS  = 16;
    localparam int FRAME_BITS = $clog2(NUM_FRAMES);
    localparam int RANK_BITS  = $clog2(NUM_FRAMES);
    localparam int COUNT_BITS = $clog2(NUM_FRAMES + 1);
    localparam int CFG_BITS   = 5;

    localparam logic [ID_BITS-1:0] EMPTY_ID = {ID_BITS{1'b1}};

    typedef struct packed {
        logic [ID_BITS-1:0]   page_id;
        logic [SIZE_BITS-1:0] page_size;
    } lru_in_t;

    typedef struct packed {
        logic                  hit;
        logic [FRAME_BITS-1:0] frame_index;
        logic                  evicted;
        logic [ID_BITS-1:0]    evicted_page_id;
    } lru_out_t;

    typedef struct packed {
        logic [ID_BITS-1:0]   page_id;
        logic [SIZE_BITS-1:0] page_size;
    } lru_entry_t;

endpackage

// ===== hdl/lru_page_frame_replacement_top.sv =====
// lru page frame replacement: frame table in a synchronous memory, ranks and valid bits in flops
//
// input channel in_valid / in_stall / in_data carries one page reference per transfer
// (page id and size tag); the block raises in_stall while a reference is in progress
// output channel out_valid / out_stall / out_data carries one result per reference:
// hit, frame index, evicted flag and evicted page id (all ones when nothing is evicted)
// config channel cfg_valid / cfg_ready / cfg_data writes frames_in_use; cfg_ready is
// always high and writes are expected only while the block is idle
// each reference scans the active frames one memory read per cycle, compares the
// id and size, tracks the first free frame and the oldest rank, then in the update
// state writes the frame back on a miss and updates all ranks in parallel
// a new reference is taken only once the current one has left the update state;
// the scan reads the frames through the single memory read port
// a finished result sits in the output register, so the next reference is taken
// while the receiver stalls; a second result waits in the update cycle until the
// output register frees up
// reset clears all valid bits, ranks and handshake state and sets frames_in_use
// to the full frame count; frame memory contents need no clearing
module lru_page_frame_replacement_top (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  lru_pkg::lru_in_t in_data,
    output logic             out_valid,
    input  logic             out_stall,
    output lru_pkg::lru_out_t out_data,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [lru_pkg::CFG_BITS-1:0] cfg_data
);
    import lru_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SCAN   = 3'b010,
        ST_UPDATE = 3'b100
    } state_t;

    state_t state_reg, state_next;

    logic [CFG_BITS-1:0]   frames_in_use_reg;
    logic [COUNT_BITS-1:0] active_frames;
    logic [COUNT_BITS-1:0] last_index;

    logic [NUM_FRAMES-1:0] valid_reg;
    logic [RANK_BITS-1:0]  rank_reg [NUM_FRAMES];

    lru_entry_t frame_mem [NUM_FRAMES];
    lru_entry_t rd_data_reg;
    logic [FRAME_BITS-1:0] rd_addr;
    logic                  mem_we;

    lru_in_t               ref_reg;
    logic [COUNT_BITS-1:0] issue_reg;
    logic [COUNT_BITS-1:0] cmp_idx_reg;
    logic [FRAME_BITS-1:0] cmp_frame;

    logic                  found_reg;
    logic [FRAME_BITS-1:0] hit_k_reg;
    logic                  free_found_reg;
    logic [FRAME_BITS-1:0] free_k_reg;
    logic [RANK_BITS-1:0]  best_rank_reg;
    logic [FRAME_BITS-1:0] victim_k_reg;
    logic [ID_BITS-1:0]    victim_id_reg;

    logic                  out_valid_reg;
    lru_out_t              out_data_reg;

    logic                  in_fire;
    logic                  out_free;
    logic                  do_update;
    logic                  evict;
    logic [FRAME_BITS-1:0] sel_k;
    logic [RANK_BITS-1:0]  hit_old_rank;
    logic                  entry_match;

    // active frame count, clamped to 1..NUM_FRAMES
    always_comb
    begin
        if (frames_in_use_reg == '0)
            active_frames = COUNT_BITS'(1);
        else if (int'(frames_in_use_reg) > NUM_FRAMES)
            active_frames = COUNT_BITS'(NUM_FRAMES);
        else
            active_frames = COUNT_BITS'(frames_in_use_reg);
    end

    assign last_index  = active_frames - COUNT_BITS'(1);
    assign in_stall    = (state_reg != ST_IDLE);
    assign in_fire     = in_valid && !in_stall;
    assign out_free    = !out_valid_reg || !out_stall;
    assign do_update   = (state_reg == ST_UPDATE) && out_free;
    assign cfg_ready   = 1'b1;
    assign out_valid   = out_valid_reg;
    assign out_data    = out_data_reg;

    assign cmp_frame   = cmp_idx_reg[FRAME_BITS-1:0];
    assign entry_match = valid_reg[cmp_frame] && (rd_data_reg.page_id == ref_reg.page_id)
                         && (rd_data_reg.page_size == ref_reg.page_size);

    assign evict        = !found_reg && !free_found_reg;
    assign sel_k        = found_reg ? hit_k_reg : (free_found_reg ? free_k_reg : victim_k_reg);
    assign hit_old_rank = rank_reg[hit_k_reg];
    assign mem_we       = do_update && !found_reg;
    assign rd_addr      = (state_reg == ST_IDLE) ? '0 : issue_reg[FRAME_BITS-1:0];

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                    state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (cmp_idx_reg == last_index)
                    state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // frame table memory
    always_ff @(posedge clk)
    begin
        if (mem_we)
            frame_mem[sel_k] <= ref_reg;
        rd_data_reg <= frame_mem[rd_addr];
    end

    // control, ranks and valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            frames_in_use_reg <= CFG_BITS'(NUM_FRAMES);
            valid_reg         <= '0;
            out_valid_reg     <= 1'b0;
            for (int i = 0; i < NUM_FRAMES; i++)
                rank_reg[i] <= '0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_valid && cfg_ready)
                frames_in_use_reg <= cfg_data;

            if (do_update)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;

            if (do_update)
            begin
                for (int i = 0; i < NUM_FRAMES; i++)
                begin
                    if (FRAME_BITS'(i) == sel_k)
                        rank_reg[i] <= '0;
                    else if (valid_reg[i])
                    begin
                        if (found_reg)
                        begin
                            if (rank_reg[i] < hit_old_rank)
                                rank_reg[i] <= rank_reg[i] + RANK_BITS'(1);
                        end
                        else if (!evict || (rank_reg[i] <= best_rank_reg))
                            rank_reg[i] <= rank_reg[i] + RANK_BITS'(1);
                    end
                end
                valid_reg[sel_k] <= 1'b1;
            end
        end
    end

    // scan datapath and result register
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            ref_reg        <= in_data;
            issue_reg      <= COUNT_BITS'(1);
            cmp_idx_reg    <= '0;
            found_reg      <= 1'b0;
            free_found_reg <= 1'b0;
            best_rank_reg  <= '0;
            hit_k_reg      <= '0;
            free_k_reg     <= '0;
            victim_k_reg   <= '0;
            victim_id_reg  <= EMPTY_ID;
        end
        else if (state_reg == ST_SCAN)
        begin
            issue_reg   <= issue_reg + COUNT_BITS'(1);
            cmp_idx_reg <= issue_reg;
            if (!found_reg && entry_match)
            begin
                found_reg <= 1'b1;
                hit_k_reg <= cmp_frame;
            end
            if (!free_found_reg && !valid_reg[cmp_frame])
            begin
                free_found_reg <= 1'b1;
                free_k_reg     <= cmp_frame;
            end
            if (rank_reg[cmp_frame] >= best_rank_reg)
            begin
                best_rank_reg <= rank_reg[cmp_frame];
                victim_k_reg  <= cmp_frame;
                victim_id_reg <= rd_data_reg.page_id;
            end
        end

        if (do_update)
        begin
            out_data_reg.hit             <= found_reg;
            out_data_reg.frame_index     <= sel_k;
            out_data_reg.evicted         <= evict;
            out_data_reg.evicted_page_id <= evict ? victim_id_reg : EMPTY_ID;
        end
    end

endmodule
